/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, empty when SYNTH is set
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define PSRL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a rising clock edge outside reset
`define PSRL_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PSRL_ASSERT(label, clk, rst_n, prop, msg)
`define PSRL_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/psrl_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psrl_pkg
// shared constants and types of the per-source rate limiter
// ---------------------------------------------------------------------------
package psrl_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // field widths
    localparam int ADDR_W  = 32;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 16;
    localparam int ENTRY_W = COUNT_W + TIME_W + ADDR_W;

    // stream widths
    localparam int IN_TDATA_W  = ADDR_W + TIME_W;
    localparam int OUT_TDATA_W = 8;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKETS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

    localparam logic [CFG_W-1:0]   RST_MAX_PACKETS   = 16'd100;
    localparam logic [CFG_W-1:0]   RST_WINDOW_LENGTH = 16'd1000;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE         = COUNT_W'(1);
    localparam logic [CNT_W-1:0]   FILL_FULL         = CNT_W'(TABLE_ENTRIES);

    // one stored source
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  start;
        logic [ADDR_W-1:0]  addr;
    } t_entry;

    // result of one packet, limited in the lowest bit
    typedef struct packed {
        logic table_full;
        logic new_source;
        logic limited;
    } t_result;

    // configuration seen by the engine
    typedef struct packed {
        logic [CFG_W-1:0] max_packets;
        logic [CFG_W-1:0] window_length;
    } t_cfg;

    // table memory read request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_ram_rd;

    // table memory write request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_ram_wr;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_AGE    = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

endpackage

/* rtl/psrl_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psrl_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module psrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/psrl_engine.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// psrl_engine
// sequencer that scans the source table with one comparator and updates it
// ---------------------------------------------------------------------------
module psrl_engine import psrl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [ADDR_W-1:0] i_source_addr,
    input  logic [TIME_W-1:0] i_now_ms,
    input  t_cfg              i_cfg,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res,
    output t_ram_rd           o_rd,
    input  t_entry            i_rd_data,
    output t_ram_wr           o_wr
);

    t_state             r_state,     n_state;
    logic [ADDR_W-1:0]  r_addr,      n_addr;
    logic [TIME_W-1:0]  r_now,       n_now;
    logic [CNT_W-1:0]   r_rd_idx,    n_rd_idx;
    logic [IDX_W-1:0]   r_data_idx,  n_data_idx;
    logic               r_found,     n_found;
    logic [IDX_W-1:0]   r_hit_idx,   n_hit_idx;
    logic [TIME_W-1:0]  r_hit_start, n_hit_start;
    logic [COUNT_W-1:0] r_hit_count, n_hit_count;
    logic               r_inside,    n_inside;
    logic [CNT_W-1:0]   r_fill,      n_fill;

    logic [TIME_W-1:0]  w_age;
    logic               w_addr_hit;
    logic [COUNT_W-1:0] w_count_inc;
    logic               w_full;
    logic               w_done;

    // shared comparator and the arithmetic of the update
    assign w_addr_hit  = (i_rd_data.addr == r_addr);
    assign w_age       = r_now - r_hit_start;
    assign w_count_inc = (r_hit_count == COUNT_MAX) ? r_hit_count : r_hit_count + COUNT_ONE;
    assign w_full      = (r_fill == FILL_FULL);
    assign w_done      = (r_state == S_FINISH) && i_res_ready;

    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_res_valid = (r_state == S_FINISH);

    // result of the packet in hand
    always_comb begin
        o_res.limited    = r_found && r_inside && ({1'b0, w_count_inc} > {1'b0, i_cfg.max_packets});
        o_res.new_source = !r_found;
        o_res.table_full = !r_found && w_full;
    end

    // table write on completion: refresh a hit or append a new source
    always_comb begin
        o_wr.en         = w_done && (r_found || !w_full);
        o_wr.addr       = r_found ? r_hit_idx : r_fill[IDX_W-1:0];
        o_wr.data.addr  = r_addr;
        o_wr.data.start = (r_found && r_inside) ? r_hit_start : r_now;
        o_wr.data.count = (r_found && r_inside) ? w_count_inc : COUNT_ONE;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_now       = r_now;
        n_rd_idx    = r_rd_idx;
        n_data_idx  = r_data_idx;
        n_found     = r_found;
        n_hit_idx   = r_hit_idx;
        n_hit_start = r_hit_start;
        n_hit_count = r_hit_count;
        n_inside    = r_inside;
        n_fill      = r_fill;
        o_rd.en     = 1'b0;
        o_rd.addr   = r_rd_idx[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_addr     = i_source_addr;
                    n_now      = i_now_ms;
                    n_found    = 1'b0;
                    n_data_idx = '0;
                    if (r_fill != '0) begin
                        o_rd.en   = 1'b1;
                        o_rd.addr = '0;
                        n_rd_idx  = CNT_W'(1);
                        n_state   = S_SCAN;
                    end else begin
                        n_state = S_AGE;
                    end
                end
            end
            S_SCAN: begin
                if (w_addr_hit) begin
                    n_found     = 1'b1;
                    n_hit_idx   = r_data_idx;
                    n_hit_start = i_rd_data.start;
                    n_hit_count = i_rd_data.count;
                    n_state     = S_AGE;
                end else if (r_rd_idx == r_fill) begin
                    n_state = S_AGE;
                end else begin
                    o_rd.en    = 1'b1;
                    n_data_idx = r_rd_idx[IDX_W-1:0];
                    n_rd_idx   = r_rd_idx + CNT_W'(1);
                end
            end
            S_AGE: begin
                n_inside = (w_age < {{(TIME_W - CFG_W){1'b0}}, i_cfg.window_length});
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                if (i_res_ready) begin
                    if (!r_found && !w_full) begin
                        n_fill = r_fill + CNT_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_now       <= n_now;
        r_rd_idx    <= n_rd_idx;
        r_data_idx  <= n_data_idx;
        r_found     <= n_found;
        r_hit_idx   <= n_hit_idx;
        r_hit_start <= n_hit_start;
        r_hit_count <= n_hit_count;
        r_inside    <= n_inside;
    end

    // checks
    `PSRL_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_FULL, "fill level beyond table size")
    `PSRL_ASSERT(a_read_stored, i_clk, i_rst_n, o_rd.en |-> (CNT_W'(o_rd.addr) < r_fill), "read of an entry never stored")
    `PSRL_ASSERT(a_fill_step, i_clk, i_rst_n, (r_fill != $past(r_fill)) |-> ($past(r_state == S_FINISH) && (r_fill == $past(r_fill) + CNT_W'(1))), "fill level moved outside a completion")
    `PSRL_ASSERT_NEVER(a_new_limited, i_clk, i_rst_n, o_res_valid && o_res.new_source && o_res.limited, "new source reported as limited")

endmodule

/* rtl/per_source_fixed_window_rate_limiter.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// per_source_fixed_window_rate_limiter
// per-source packet rate limiter over fixed windows, with a 64-entry table
// ---------------------------------------------------------------------------
//  channel   direction  handshake                contents
//  s         in         i_s_tvalid / o_s_tready  source_addr, now_ms
//  m         out        o_m_tvalid / i_m_tready  limited, new_source, table_full
//  cfg       in         i_cfg_we                 max_packets, window_length
//
//  the stored entries are read in order, one table entry read a cycle, up to a hit or
//  the last stored source; S_AGE then checks the window and S_FINISH holds the result
//  the next transfer in is taken in the idle cycle after the engine hands on its result
//  the result waits in an output register, so a new packet is taken meanwhile
//  reset is synchronous; the table needs no clearing pass, only the fill count
//  a stalled result holds the sequencer in its last step until it moves out
// ---------------------------------------------------------------------------
module per_source_fixed_window_rate_limiter import psrl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [31:0] source_addr, [63:32] now_ms
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [0] limited, [1] new_source, [2] table_full
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    logic [CFG_W-1:0] r_max_packets;
    logic [CFG_W-1:0] r_window_length;
    logic             r_out_valid;
    t_result          r_out_res;

    t_cfg    w_cfg;
    logic    w_res_valid;
    logic    w_res_ready;
    t_result w_res;
    t_ram_rd w_rd;
    t_ram_wr w_wr;
    t_entry  w_rd_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_packets   <= RST_MAX_PACKETS;
            r_window_length <= RST_WINDOW_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAX_PACKETS:   r_max_packets   <= i_cfg_data;
                REG_WINDOW_LENGTH: r_window_length <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.max_packets   = r_max_packets;
    assign w_cfg.window_length = r_window_length;

    // sequencer and compare unit
    psrl_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_tvalid),
        .o_in_ready    (o_s_tready),
        .i_source_addr (i_s_tdata[ADDR_W-1:0]),
        .i_now_ms      (i_s_tdata[ADDR_W +: TIME_W]),
        .i_cfg         (w_cfg),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res         (w_res),
        .o_rd          (w_rd),
        .i_rd_data     (w_rd_data),
        .o_wr          (w_wr)
    );

    // source table
    psrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_wr.en),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_re    (w_rd.en),
        .i_raddr (w_rd.addr),
        .o_rdata (w_rd_data)
    );

    // output register, free when empty or being emptied
    assign w_res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out_res <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_res);

endmodule

/* sim/per_source_fixed_window_rate_limiter_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// per_source_fixed_window_rate_limiter_tb
// self-checking bench for the per-source rate limiter: packets are streamed
// in with random gaps while results are drained with random stalls, and each
// verdict is checked against a behavioural table of sources kept here
// ---------------------------------------------------------------------------
module per_source_fixed_window_rate_limiter_tb;
    import psrl_pkg::*;

    localparam int LIMIT       = 3_000_000;  // cycle ceiling for the whole run
    localparam int BURST_PKTS  = 100;        // packets in the back-to-back burst
    localparam int RAND_PKTS   = 185;        // packets per random phase
    localparam int N_PHASES    = 7;
    localparam int SETTLE      = 8;          // cycles before a register write
    localparam int END_WAIT    = 80;         // longer than the worst packet latency
    localparam int HOLD_CYCLES = 400;        // long receiver hold-off

    // one arriving packet, source address in the low half
    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [ADDR_W-1:0] src;
    } t_arrival;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;   // [31:0] source_addr, [63:32] now_ms
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;         // [0] limited, [1] new_source, [2] table_full
    logic                   i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx  = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    // source table as the block should hold it
    logic              tbl_valid [TABLE_ENTRIES];
    logic [ADDR_W-1:0] tbl_addr  [TABLE_ENTRIES];
    logic [TIME_W-1:0] tbl_start [TABLE_ENTRIES];
    logic [COUNT_W-1:0] tbl_count [TABLE_ENTRIES];
    int                tbl_fill  = 0;
    logic [CFG_W-1:0]  cfg_max    = RST_MAX_PACKETS;
    logic [CFG_W-1:0]  cfg_window = RST_WINDOW_LENGTH;

    t_arrival          arrival_q [$];
    t_result           verdict_q [$];
    logic [ADDR_W-1:0] known_srcs [$];
    logic [TIME_W-1:0] clk_ms = '0;

    int   pkts_sent   = 0;
    int   pkts_taken  = 0;
    int   fail_count  = 0;
    int   cycle_count = 0;
    logic run         = 1'b0;
    logic idle_off    = 1'b0;
    logic hold_go     = 1'b0;
    logic s_xfer      = 1'b0;
    logic m_xfer      = 1'b0;

    per_source_fixed_window_rate_limiter u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run ceiling
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // verdict for one packet, updating the source table
    function automatic t_result rate_decide(input logic [ADDR_W-1:0] src,
                                            input logic [TIME_W-1:0] now);
        t_result           r;
        int                hit;
        int                k;
        logic [TIME_W-1:0] age;
        r   = '0;
        hit = -1;
        for (k = 0; k < TABLE_ENTRIES; k++)
            if (hit < 0 && tbl_valid[k] && tbl_addr[k] == src)
                hit = k;
        if (hit >= 0) begin
            // age wraps modulo 2^32
            age = now - tbl_start[hit];
            if (age < TIME_W'(cfg_window)) begin
                if (tbl_count[hit] != COUNT_MAX)
                    tbl_count[hit] = tbl_count[hit] + COUNT_ONE;
                r.limited = (tbl_count[hit] > cfg_max);
            end else begin
                tbl_count[hit] = COUNT_ONE;
                tbl_start[hit] = now;
            end
        end else begin
            r.new_source = 1'b1;
            if (tbl_fill < TABLE_ENTRIES) begin
                tbl_valid[tbl_fill] = 1'b1;
                tbl_addr[tbl_fill]  = src;
                tbl_start[tbl_fill] = now;
                tbl_count[tbl_fill] = COUNT_ONE;
                tbl_fill++;
            end else begin
                r.table_full = 1'b1;
            end
        end
        return r;
    endfunction

    // gap length: mostly short, now and then long, with calm stretches
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // transfer sampling, checking and prediction at the rising edge
    always @(posedge i_clk) begin
        t_result want;
        s_xfer <= i_rst_n && i_s_tvalid && o_s_tready;
        m_xfer <= i_rst_n && o_m_tvalid && i_m_tready;
        if (i_rst_n) begin
            // results first, so a packet taken on the same edge is not matched
            if (o_m_tvalid && i_m_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("result with nothing expected: tdata %h", o_m_tdata);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_m_tdata[0] !== want.limited) begin
                        $error("limited: expected %0b, actual %0b", want.limited, o_m_tdata[0]);
                        fail_count++;
                    end
                    if (o_m_tdata[1] !== want.new_source) begin
                        $error("new_source: expected %0b, actual %0b",
                               want.new_source, o_m_tdata[1]);
                        fail_count++;
                    end
                    if (o_m_tdata[2] !== want.table_full) begin
                        $error("table_full: expected %0b, actual %0b",
                               want.table_full, o_m_tdata[2]);
                        fail_count++;
                    end
                    if (o_m_tdata[OUT_TDATA_W-1:3] !== '0) begin
                        $error("padding: expected %h, actual %h", 5'h00,
                               o_m_tdata[OUT_TDATA_W-1:3]);
                        fail_count++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                verdict_q.push_back(rate_decide(i_s_tdata[ADDR_W-1:0],
                                                i_s_tdata[IN_TDATA_W-1:ADDR_W]));
                pkts_taken++;
            end
        end
    end

    // packet driver, fed from the arrival queue
    int s_gap  = 0;
    int s_calm = 0;
    always @(negedge i_clk) begin
        if (s_xfer || !i_s_tvalid) begin
            if (s_xfer)
                s_gap = idle_off ? 0 : pick_gap(s_calm);
            if (!run) begin
                i_s_tvalid <= 1'b0;
            end else if (s_gap > 0 && !idle_off) begin
                s_gap--;
                i_s_tvalid <= 1'b0;
            end else if (arrival_q.size() > 0) begin
                i_s_tdata  <= arrival_q.pop_front();
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off once asked for
    int   m_gap     = 0;
    int   m_calm    = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (m_xfer)
            m_gap = idle_off ? 0 : pick_gap(m_calm);
        if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (!run) begin
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (m_gap > 0 && !idle_off) begin
            m_gap--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic offer(input logic [ADDR_W-1:0] src, input logic [TIME_W-1:0] now);
        t_arrival a;
        a.src = src;
        a.now = now;
        arrival_q.push_back(a);
        pkts_sent++;
        clk_ms = now;
    endtask

    // wait until every packet is through and every result is out
    task automatic drain();
        while (arrival_q.size() != 0 || pkts_taken != pkts_sent || verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == REG_MAX_PACKETS)
            cfg_max = val;
        else if (idx == REG_WINDOW_LENGTH)
            cfg_window = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // random packets: hot sources, the wider known set and fresh addresses
    task automatic gen_random(input int n);
        int                i;
        int                r;
        logic [ADDR_W-1:0] src;
        logic [TIME_W-1:0] step;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                src = known_srcs[$urandom_range(0, 3)];
            end else if (r < 85) begin
                src = known_srcs[$urandom_range(0, known_srcs.size() - 1)];
            end else begin
                src = $urandom;
                known_srcs.push_back(src);
            end
            r = $urandom_range(0, 19);
            if (r < 12)
                step = $urandom_range(0, 2);
            else if (r < 18)
                step = $urandom_range(0, 2 * int'(cfg_window) + 2);
            else
                step = $urandom;
            offer(src, clk_ms + step);
        end
    endtask

    // stimulus
    initial begin
        int                p;
        int                i;
        logic [CFG_W-1:0]  ph_max [N_PHASES];
        logic [CFG_W-1:0]  ph_win [N_PHASES];
        ph_max = '{16'd3, 16'd0, 16'hFFFF, 16'd1, 16'd2, 16'd10, 16'd4};
        ph_win = '{16'd50, 16'd20, 16'hFFFF, 16'd1, 16'd0, 16'd500, 16'hFFFF};
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_addr[i]  = '0;
            tbl_start[i] = '0;
            tbl_count[i] = '0;
        end
        known_srcs = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h1234_5678};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run = 1'b1;

        // extreme addresses, window crossing the time wrap, window expiry
        offer(32'h0000_0000, 32'hFFFF_FFF0);
        offer(32'hFFFF_FFFF, 32'hFFFF_FFF8);
        offer(32'h0000_0000, 32'h0000_0005);
        offer(32'hFFFF_FFFF, 32'h0000_0010);
        offer(32'h0000_0000, 32'h0000_03E0);
        drain();

        // zero maximum: only the opening packet of a window passes
        set_reg(REG_MAX_PACKETS, 16'd0);
        offer(32'hA5A5_5A5A, 32'd2000);
        offer(32'hA5A5_5A5A, 32'd2001);
        offer(32'hA5A5_5A5A, 32'd2999);
        offer(32'hA5A5_5A5A, 32'd3000);
        drain();

        // zero window: every known packet opens a new window
        set_reg(REG_WINDOW_LENGTH, 16'd0);
        offer(32'hA5A5_5A5A, 32'd3000);
        offer(32'h0000_0000, 32'd3000);
        drain();

        // longest window, limit just past the first packet
        set_reg(REG_MAX_PACKETS, 16'd1);
        set_reg(REG_WINDOW_LENGTH, 16'hFFFF);
        offer(32'h1234_5678, 32'h8000_0000);
        offer(32'h1234_5678, 32'h8000_0000);
        offer(32'h1234_5678, 32'h8000_0000);
        offer(32'h1234_5678, 32'h8000_FFFE);
        offer(32'h1234_5678, 32'h8000_FFFF);
        drain();

        // back-to-back burst from one source inside a single window,
        // crossing the limit part way through
        set_reg(REG_MAX_PACKETS, 16'd60);
        idle_off = 1'b1;
        for (i = 0; i < BURST_PKTS; i++)
            offer(32'h0000_0000, 32'h4000_0000);
        drain();
        idle_off = 1'b0;

        // random phases over a spread of settings
        for (p = 0; p < N_PHASES; p++) begin
            if (p % 2 == 0) begin
                set_reg(REG_WINDOW_LENGTH, ph_win[p]);
                set_reg(REG_MAX_PACKETS, ph_max[p]);
            end else begin
                set_reg(REG_MAX_PACKETS, ph_max[p]);
                set_reg(REG_WINDOW_LENGTH, ph_win[p]);
            end
            gen_random(RAND_PKTS);
            // long receiver hold-off while the first random phase streams in
            if (p == 0) begin
                repeat (50) @(negedge i_clk);
                hold_go = 1'b1;
            end
            drain();
        end

        // let any stray result show up
        repeat (END_WAIT) @(negedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/psrl_pkg.sv
rtl/psrl_ram.sv
rtl/psrl_engine.sv
rtl/per_source_fixed_window_rate_limiter.sv
sim/per_source_fixed_window_rate_limiter_tb.sv
